// File: hdl/ses_pkg.sv
// Shared widths and types for the short exponent signature block.
// No dependencies; used by short_exponent_signature and ses_checker.
`default_nettype none

package ses_pkg;

   // Field widths fixed by the interface
   localparam int NUM_VARS_W = 11;   // num_vars register
   localparam int EXP_W      = 32;   // exponent per transaction
   localparam int SIG_W      = 64;   // signature per result
   localparam int POS_W      = 7;    // bit positions and field widths, 0..64

   // Signature construction mode, chosen by the variable count
   typedef enum logic [1:0] {
      MODE_THERMO,   // N <= word bits: thermometer field per variable
      MODE_BITMAP,   // word bits < N < 2*word bits: one bit per variable, first word bits only
      MODE_COUNT     // N >= 2*word bits: count of nonzero exponents
   } mode_type;

endpackage

`default_nettype wire

// File: hdl/short_exponent_signature.sv
// Short exponent vector signature builder, top level.
// Depends on ses_pkg for widths and the mode type.
`default_nettype none

//  channel  | ports                         | transaction
//  ---------+-------------------------------+----------------------------------
//  req      | req_tvalid/tready/tdata[31:0] | one exponent, variables in order
//  rsp      | rsp_tvalid/tready/tdata[63:0] | signature after the last variable
//  csr      | csr_we, csr_wdata[10:0]       | write of num_vars
//
//  One exponent is taken per cycle while req is not stalled; the signature is
//  registered and shows on rsp in the cycle after the last exponent of a monomial is accepted.
//  The field-width table lookup on a csr write sets up all later items.
//  Synchronous reset leaves num_vars at 1.
//  req stalls only while a finished signature waits and rsp_tready is low.

module short_exponent_signature #(
   parameter int WORD_BITS = 64,
   parameter int MAX_VARS  = 1024
) (
   input  wire                               clock,
   input  wire                               reset,
   // req_tdata: [31:0] exponent
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [ses_pkg::EXP_W-1:0]         req_tdata,
   // rsp_tdata: [63:0] signature
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [ses_pkg::SIG_W-1:0]         rsp_tdata,
   input  wire                               csr_we,
   input  wire  [ses_pkg::NUM_VARS_W-1:0]    csr_wdata
);

   localparam int TAB_DEPTH = 2 ** ses_pkg::POS_W;
   localparam logic [ses_pkg::SIG_W-1:0] WORD_MASK =
      (WORD_BITS >= ses_pkg::SIG_W) ? {ses_pkg::SIG_W{1'b1}}
                                    : ((ses_pkg::SIG_W'(1) << WORD_BITS) - 1'b1);
   localparam logic [ses_pkg::NUM_VARS_W:0] TWO_WORDS =
      (ses_pkg::NUM_VARS_W + 1)'(2 * WORD_BITS);

   // Field width tables, worked out at elaboration: WORD_BITS / n and mod n
   logic [ses_pkg::POS_W-1:0] base_tab [TAB_DEPTH];
   logic [ses_pkg::POS_W-1:0] wide_tab [TAB_DEPTH];

   for (genvar Nv = 0; Nv < TAB_DEPTH; Nv++) begin : g_tab
      if (Nv >= 1 && Nv <= WORD_BITS) begin : g_ent
         assign base_tab[Nv] = ses_pkg::POS_W'(WORD_BITS / Nv);
         assign wide_tab[Nv] = ses_pkg::POS_W'(WORD_BITS % Nv);
      end else begin : g_nil
         assign base_tab[Nv] = ses_pkg::POS_W'(1);
         assign wide_tab[Nv] = '0;
      end
   end

   // Configuration and derived state
   logic [ses_pkg::NUM_VARS_W-1:0] nvars_ff, nvars_in;
   logic [ses_pkg::POS_W-1:0]      base_ff, base_in;
   logic [ses_pkg::POS_W-1:0]      wide_ff, wide_in;
   ses_pkg::mode_type              mode_ff, mode_in;

   // Per-monomial state
   logic [ses_pkg::NUM_VARS_W-1:0] var_count_ff, var_count_in;
   logic [ses_pkg::POS_W-1:0]      bit_pos_ff, bit_pos_in;
   logic [ses_pkg::SIG_W-1:0]      acc_ff, acc_in;
   logic [ses_pkg::POS_W-1:0]      nz_count_ff, nz_count_in;

   // Result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ses_pkg::SIG_W-1:0]      rsp_data_ff, rsp_data_in;

   logic [ses_pkg::NUM_VARS_W-1:0] eff_vars;
   logic [ses_pkg::POS_W-1:0]      field_w;
   logic [ses_pkg::POS_W-1:0]      ones;
   logic [ses_pkg::SIG_W-1:0]      therm;
   logic [ses_pkg::SIG_W-1:0]      acc_upd;
   logic [ses_pkg::POS_W-1:0]      nz_upd;
   logic                           exp_nz;
   logic                           last_var;
   logic                           req_fire;

   // Clamp written variable count to 1..MAX_VARS and pick the mode
   always_comb begin
      if (csr_wdata == '0) begin
         eff_vars = ses_pkg::NUM_VARS_W'(1);
      end else if (32'(csr_wdata) > 32'(MAX_VARS)) begin
         eff_vars = ses_pkg::NUM_VARS_W'(MAX_VARS);
      end else begin
         eff_vars = csr_wdata;
      end
      base_in = base_tab[eff_vars[ses_pkg::POS_W-1:0]];
      wide_in = wide_tab[eff_vars[ses_pkg::POS_W-1:0]];
      if (32'(eff_vars) <= 32'(WORD_BITS)) begin
         mode_in = ses_pkg::MODE_THERMO;
      end else if ({1'b0, eff_vars} < TWO_WORDS) begin
         mode_in = ses_pkg::MODE_BITMAP;
         base_in = ses_pkg::POS_W'(1);
         wide_in = '0;
      end else begin
         mode_in = ses_pkg::MODE_COUNT;
         base_in = ses_pkg::POS_W'(1);
         wide_in = '0;
      end
      nvars_in = eff_vars;
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign exp_nz     = (req_tdata != '0);
   assign last_var   = (var_count_ff == nvars_ff - 1'b1);

   // Thermometer field of this variable
   always_comb begin
      field_w = base_ff + ((ses_pkg::POS_W'(var_count_ff) < wide_ff &&
                            var_count_ff < ses_pkg::NUM_VARS_W'(TAB_DEPTH))
                           ? ses_pkg::POS_W'(1) : '0);
      ones    = (req_tdata < ses_pkg::EXP_W'(field_w))
                ? req_tdata[ses_pkg::POS_W-1:0] : field_w;
      therm   = ~({ses_pkg::SIG_W{1'b1}} << ones);
   end

   // Accumulator and counter update for one exponent
   always_comb begin
      acc_upd = acc_ff;
      nz_upd  = nz_count_ff;
      case (mode_ff)
         ses_pkg::MODE_THERMO: begin
            acc_upd = acc_ff | (therm << bit_pos_ff);
         end
         ses_pkg::MODE_BITMAP: begin
            if (exp_nz && 32'(var_count_ff) < 32'(WORD_BITS)) begin
               acc_upd = acc_ff | (ses_pkg::SIG_W'(1) << var_count_ff);
            end
         end
         ses_pkg::MODE_COUNT: begin
            if (exp_nz && 32'(nz_count_ff) < 32'(WORD_BITS)) begin
               nz_upd = nz_count_ff + 1'b1;
            end
         end
         default: begin
            acc_upd = acc_ff;
         end
      endcase
   end

   // Next state: csr write restarts, accepted transaction advances
   always_comb begin
      var_count_in = var_count_ff;
      bit_pos_in   = bit_pos_ff;
      acc_in       = acc_ff;
      nz_count_in  = nz_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (csr_we) begin
         var_count_in = '0;
         bit_pos_in   = '0;
         acc_in       = '0;
         nz_count_in  = '0;
      end else if (req_fire) begin
         if (last_var) begin
            var_count_in = '0;
            bit_pos_in   = '0;
            acc_in       = '0;
            nz_count_in  = '0;
            rsp_valid_in = 1'b1;
            if (mode_ff == ses_pkg::MODE_COUNT) begin
               rsp_data_in = ~({ses_pkg::SIG_W{1'b1}} << nz_upd) & WORD_MASK;
            end else begin
               rsp_data_in = acc_upd & WORD_MASK;
            end
         end else begin
            var_count_in = var_count_ff + 1'b1;
            bit_pos_in   = bit_pos_ff + field_w;
            acc_in       = acc_upd;
            nz_count_in  = nz_upd;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nvars_ff     <= ses_pkg::NUM_VARS_W'(1);
         base_ff      <= ses_pkg::POS_W'(WORD_BITS);
         wide_ff      <= '0;
         mode_ff      <= ses_pkg::MODE_THERMO;
         var_count_ff <= '0;
         bit_pos_ff   <= '0;
         acc_ff       <= '0;
         nz_count_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            nvars_ff <= nvars_in;
            base_ff  <= base_in;
            wide_ff  <= wide_in;
            mode_ff  <= mode_in;
         end
         var_count_ff <= var_count_in;
         bit_pos_ff   <= bit_pos_in;
         acc_ff       <= acc_in;
         nz_count_ff  <= nz_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// File: hdl/ses_checker.sv
// Port-level checks for short_exponent_signature, bound to the top level.
// Depends on ses_pkg for widths.
`default_nettype none

module ses_checker #(
   parameter int WORD_BITS = 64
) (
   input wire                        clock,
   input wire                        reset,
   input wire                        req_tvalid,
   input wire                        req_tready,
   input wire                        rsp_tvalid,
   input wire                        rsp_tready,
   input wire [ses_pkg::SIG_W-1:0]   rsp_tdata
);

   localparam logic [ses_pkg::SIG_W-1:0] WORD_MASK =
      (WORD_BITS >= ses_pkg::SIG_W) ? {ses_pkg::SIG_W{1'b1}}
                                    : ((ses_pkg::SIG_W'(1) << WORD_BITS) - 1'b1);

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // No result right after reset
   a_rst_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Signature never sets bits above the word
   a_sig_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata & ~WORD_MASK) == '0)
      else $error("signature bits above word size");

   // Input is open whenever no result is waiting
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // A new result only follows an accepted exponent
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result without input transaction");

endmodule

bind short_exponent_signature ses_checker #(.WORD_BITS(WORD_BITS)) u_ses_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// File: bench/short_exponent_signature_tb.sv
// Testbench for short_exponent_signature: streams monomial exponents, predicts each
// signature in all three modes and checks every rsp transaction in order.
// Depends on ses_pkg and the short_exponent_signature RTL.
`default_nettype none

module short_exponent_signature_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORD_BITS    = 64;
   localparam int MAX_VARS     = 1024;
   localparam int SETTLE       = 4;        // cycles after the last signature
   localparam int RANDOM_ITEMS = 400;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SHOWN_ERRORS = 10;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [ses_pkg::EXP_W-1:0]       req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [ses_pkg::SIG_W-1:0]       rsp_tdata;
   logic                            csr_we     = 1'b0;
   logic [ses_pkg::NUM_VARS_W-1:0]  csr_wdata  = '0;

   // shared stimulus knobs
   bit          burst_mode = 1'b0;   // both sides run without gaps
   int unsigned zero_pct   = 30;     // share of zero exponents
   int unsigned mismatches = 0;
   int unsigned sigs_seen  = 0;
   int unsigned cycle_count;

   // predictor state
   logic [ses_pkg::NUM_VARS_W-1:0]  num_vars_reg;
   logic [ses_pkg::NUM_VARS_W-1:0]  seen_vars;
   logic [ses_pkg::POS_W-1:0]       field_pos;
   logic [ses_pkg::SIG_W-1:0]       sig_acc;
   logic [ses_pkg::POS_W-1:0]       nonzero_seen;
   logic [ses_pkg::POS_W-1:0]       base_width;
   logic [ses_pkg::POS_W-1:0]       wide_vars;
   logic [ses_pkg::SIG_W-1:0]       pending_sigs [$];

   short_exponent_signature #(
      .WORD_BITS (WORD_BITS),
      .MAX_VARS  (MAX_VARS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [63:0] low_ones(int unsigned k);
      if (k == 0) return '0;
      if (k >= 64) return '1;
      return (64'd1 << k) - 64'd1;
   endfunction

   // zero counts as one variable, anything above the maximum is clamped
   function automatic int unsigned active_vars();
      if (num_vars_reg == 0) return 1;
      if (num_vars_reg > MAX_VARS) return MAX_VARS;
      return 32'(num_vars_reg);
   endfunction

   function automatic ses_pkg::mode_type mode_of(int unsigned n);
      if (n <= WORD_BITS) return ses_pkg::MODE_THERMO;
      if (n < 2 * WORD_BITS) return ses_pkg::MODE_BITMAP;
      return ses_pkg::MODE_COUNT;
   endfunction

   // drop the monomial in progress and derive the field widths again
   function automatic void restart_monomial();
      int unsigned n;
      int unsigned w;
      n = active_vars();
      w = WORD_BITS / n;
      seen_vars    = '0;
      field_pos    = '0;
      sig_acc      = '0;
      nonzero_seen = '0;
      if (w == 0) begin
         base_width = 7'd1;
         wide_vars  = '0;
      end else begin
         base_width = ses_pkg::POS_W'(w);
         wide_vars  = ses_pkg::POS_W'(WORD_BITS - w * n);
      end
   endfunction

   // fold one exponent in; queue the signature once the monomial is complete
   function automatic void absorb_exponent(logic [31:0] e);
      int unsigned      n;
      int unsigned      width;
      int unsigned      ones;
      logic [63:0]      sig;
      ses_pkg::mode_type m;
      n = active_vars();
      m = mode_of(n);
      case (m)
         ses_pkg::MODE_THERMO: begin
            width = base_width + ((seen_vars < wide_vars) ? 1 : 0);
            ones  = (e < width) ? e : width;
            if (ones > 0 && field_pos < 64)
               sig_acc |= low_ones(ones) << field_pos;
            field_pos = ses_pkg::POS_W'(field_pos + width);
         end
         ses_pkg::MODE_BITMAP: begin
            if (e != 0 && seen_vars < WORD_BITS)
               sig_acc |= 64'd1 << seen_vars;
         end
         default: begin
            if (e != 0 && nonzero_seen < WORD_BITS)
               nonzero_seen++;
         end
      endcase
      seen_vars++;
      if (seen_vars < n) return;
      sig = (m == ses_pkg::MODE_COUNT) ? low_ones(nonzero_seen) : sig_acc;
      pending_sigs.push_back(sig & low_ones(WORD_BITS));
      seen_vars    = '0;
      field_pos    = '0;
      sig_acc      = '0;
      nonzero_seen = '0;
   endfunction

   // ------------------------------------------------------------------ checker

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS)
         $display("MISMATCH %s: expected %h, actual %h", what, want, got);
   endtask

   // result check first, then register writes, then accepted exponents
   always @(posedge clock) begin
      if (reset) begin
         num_vars_reg = 11'd1;
         restart_monomial();
         pending_sigs.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sigs_seen++;
            if (pending_sigs.size() == 0)
               note_mismatch("signature with none pending", '0, rsp_tdata);
            else if (rsp_tdata !== pending_sigs[0])
               note_mismatch("signature", pending_sigs.pop_front(), rsp_tdata);
            else
               void'(pending_sigs.pop_front());
         end
         if (csr_we) begin
            num_vars_reg = csr_wdata;
            restart_monomial();
         end
         if (req_tvalid && req_tready)
            absorb_exponent(req_tdata);
      end
   end

   // ------------------------------------------------------------------ drivers

   function automatic int unsigned pick_gap();
      if (burst_mode) return 0;
      return $urandom_range(0, 19);
   endfunction

   // result side: random stall before each transaction
   initial begin
      int unsigned stall;
      @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // one exponent transaction; valid stays high on return
   task automatic send_exponent(input logic [31:0] e);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= e;
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off until every pending signature has come back; the first edge
   // lets the predictor take in the last accepted exponent
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_sigs.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_num_vars(input logic [10:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [31:0] draw_exponent();
      if ($urandom_range(0, 99) < zero_pct) return '0;
      case ($urandom_range(0, 4))
         0:       return $urandom_range(1, 8);
         1:       return $urandom_range(1, 70);
         2:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // --------------------------------------------------------------------- tests

   // reset leaves one variable with a full-word field; zero is read as one
   task automatic test_single_var_fields();
      send_exponent(32'd0);
      send_exponent(32'd1);
      send_exponent(32'd63);
      send_exponent(32'd64);
      send_exponent(32'hFFFF_FFFF);
      write_num_vars(11'd0);
      send_exponent(32'd65);
      send_exponent(32'd2);
   endtask

   // uneven split: the first variable takes the extra bit
   task automatic test_split_fields();
      write_num_vars(11'd3);
      send_exponent(32'hFFFF_FFFF);
      send_exponent(32'd21);
      send_exponent(32'd0);
      write_num_vars(11'd2);
      send_exponent(32'd33);
      send_exponent(32'd32);
   endtask

   // a register write drops the half-built monomial
   task automatic test_abandoned_monomial();
      write_num_vars(11'd3);
      send_exponent(32'd5);
      send_exponent(32'd5);
      write_num_vars(11'd2);
      send_exponent(32'd1);
      send_exponent(32'd0);
   endtask

   // whole monomials with random content across all modes, mode edges first
   task automatic test_random_monomials();
      int unsigned edge_vars [5] = '{1, 64, 65, 127, 128};
      int unsigned vars;
      int unsigned monos;
      int unsigned partial;
      int unsigned items_sent;
      int unsigned phase;
      items_sent = 0;
      phase      = 0;
      while (items_sent < RANDOM_ITEMS || sigs_seen < 24) begin
         if (phase < 5)
            vars = edge_vars[phase];
         else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: vars = $urandom_range(1, 8);
               4, 5:       vars = $urandom_range(9, 64);
               6, 7:       vars = $urandom_range(65, 127);
               default:    vars = $urandom_range(128, 160);
            endcase
         end
         phase++;
         case ($urandom_range(0, 3))
            0:       zero_pct = 0;
            1:       zero_pct = 15;
            2:       zero_pct = 50;
            default: zero_pct = 90;
         endcase
         write_num_vars(ses_pkg::NUM_VARS_W'(vars));
         burst_mode = ($urandom_range(0, 3) == 0);
         monos = (vars <= WORD_BITS) ? $urandom_range(1, 6) : 1;
         repeat (monos * vars) begin
            send_exponent(draw_exponent());
            items_sent++;
         end
         // now and then leave a monomial half done for the next write
         if (vars > 1 && $urandom_range(0, 3) == 0) begin
            partial = $urandom_range(1, vars - 1);
            repeat (partial) send_exponent(draw_exponent());
         end
         burst_mode = 1'b0;
      end
   endtask

   // largest monomial, clamped from the top register value
   task automatic test_widest_monomials();
      zero_pct = 97;
      write_num_vars(11'h7FF);
      repeat (MAX_VARS) send_exponent(draw_exponent());
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_single_var_fields();
      test_split_fields();
      test_abandoned_monomial();
      test_random_monomials();
      test_widest_monomials();
      wait_idle();
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TIMEOUT after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
